// File: hdl/edh_pkg.sv
// edh_pkg: shared types, register indexes and arithmetic helpers
// for the error diffusion halftone block; no dependencies
package edh_pkg;

	localparam int ErrW = 11;
	localparam int PixW = 8;

	typedef logic signed [ErrW-1:0] err_t;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_LINE_COUNT = 2'd1,
		REG_THRESHOLD  = 2'd2
	} reg_idx_t;

	localparam logic [11:0] LineWidthRst = 12'd640;
	localparam logic [15:0] LineCountRst = 16'd480;
	localparam logic [7:0]  ThresholdRst = 8'd127;
	localparam logic [7:0]  PixWhite     = 8'd255;
	localparam logic [7:0]  PixBlack     = 8'd0;

	// clamp a 13-bit signed sum to -1024..1023
	function automatic err_t sat_err(input logic signed [12:0] v);
		err_t r;
		if (v > 13'sd1023) begin
			r = 11'sd1023;
		end else if (v < -13'sd1024) begin
			r = -11'sd1024;
		end else begin
			r = v[10:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/edh_ram.sv
// edh_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module edh_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/error_diffusion_halftone.sv
// error_diffusion_halftone: top level of the halftone block
// depends on edh_pkg and edh_ram (line store of row errors)
// a pixel beat is registered in stage 1 and then in the output register
// one pixel per clock while out_stall is low; right_q closes the right error loop
// the line store read is issued on accept and forwarded from a same-edge write
// reset clears counters, error carries, pipeline valids and config to defaults
// the line store itself is not cleared; it is written by each row before use
module error_diffusion_halftone #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_pixel,
	output logic        end_of_line,
	output logic        end_of_frame
);
	import edh_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = (CW + 1 > 12) ? CW + 1 : 12;

	logic [11:0] line_width_q;
	logic [15:0] line_count_q;
	logic [7:0]  threshold_q;

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	err_t          right_q;
	err_t          diag_q;

	logic          valid_s1;
	logic [7:0]    pix_s1;
	logic [CW-1:0] idx_s1;
	logic          first_row_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic          fwd_hit_s1;
	err_t          fwd_data_s1;

	logic          out_valid_q;
	logic [7:0]    out_pixel_q;
	logic          eol_q;
	logic          eof_q;

	logic          cfg_wr;
	reg_idx_t      cfg_idx;
	logic          accept;
	logic          adv_s1;
	logic [PW-1:0] lw_x;
	logic [PW-1:0] max_x;
	logic [PW-1:0] last_pos;
	logic [15:0]   last_row_pos;
	logic          last_col_s0;
	logic          last_row_s0;

	logic [10:0]        ram_rdata;
	err_t               below;
	logic signed [12:0] sum;
	err_t               corr;
	logic               white;
	logic [11:0]        delta;
	logic [13:0]        prod;
	logic [13:0]        prod_r;
	err_t               part;
	logic [11:0]        delta_r;
	err_t               diag_new;
	logic [11:0]        wsum;
	err_t               wr_data;
	logic               wr_en;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_LINE_WIDTH: prdata = {20'd0, line_width_q};
			REG_LINE_COUNT: prdata = {16'd0, line_count_q};
			REG_THRESHOLD:  prdata = {24'd0, threshold_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LineWidthRst;
			line_count_q <= LineCountRst;
			threshold_q  <= ThresholdRst;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LINE_WIDTH: line_width_q <= pwdata[11:0];
				REG_LINE_COUNT: line_count_q <= pwdata[15:0];
				REG_THRESHOLD:  threshold_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// position flags
	assign lw_x  = PW'(line_width_q);
	assign max_x = PW'(MAX_WIDTH);
	always_comb begin
		priority if (lw_x == '0) begin
			last_pos = '0;
		end else if (lw_x > max_x) begin
			last_pos = max_x - PW'(1);
		end else begin
			last_pos = lw_x - PW'(1);
		end
	end
	assign last_row_pos = (line_count_q == 16'd0) ? 16'd0 : line_count_q - 16'd1;
	assign last_col_s0  = PW'(col_q) >= last_pos;
	assign last_row_s0  = row_q >= last_row_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col_s0) begin
				col_q <= '0;
				row_q <= last_row_s0 ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line store
	edh_ram #(
		.WIDTH(ErrW),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// stage 1: correct, threshold, diffuse
	always_comb begin
		priority if (first_row_s1) begin
			below = '0;
		end else if (fwd_hit_s1) begin
			below = fwd_data_s1;
		end else begin
			below = ram_rdata;
		end
	end

	assign sum   = $signed({5'd0, pix_s1}) + $signed({{2{right_q[10]}}, right_q})
		+ $signed({{2{below[10]}}, below});
	assign corr  = sat_err(sum);
	assign white = corr > $signed({3'd0, threshold_q});
	assign delta = {corr[10], corr} - (white ? {4'd0, PixWhite} : {4'd0, PixBlack});

	// 3/8 and 1/4 with truncation toward zero
	assign prod     = {{2{delta[11]}}, delta} + {delta[11], delta, 1'b0};
	assign prod_r   = prod + (prod[13] ? 14'd7 : 14'd0);
	assign part     = prod_r[13:3];
	assign delta_r  = delta + (delta[11] ? 12'd3 : 12'd0);
	assign diag_new = {delta_r[11], delta_r[11:2]};
	assign wsum     = {part[10], part} + {diag_q[10], diag_q};

	assign wr_data = last_col_s1 ? diag_q : sat_err({wsum[11], wsum});
	assign wr_en   = adv_s1 && !last_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= in_pixel;
			idx_s1       <= col_q;
			first_row_s1 <= row_q == 16'd0;
			last_col_s1  <= last_col_s0;
			last_row_s1  <= last_row_s0;
			fwd_hit_s1   <= wr_en && (idx_s1 == col_q);
			fwd_data_s1  <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			diag_q  <= '0;
		end else if (adv_s1) begin
			if (last_col_s1) begin
				right_q <= '0;
				diag_q  <= '0;
			end else if (!last_row_s1) begin
				right_q <= part;
				diag_q  <= diag_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_pixel_q <= white ? PixWhite : PixBlack;
			eol_q       <= last_col_s1;
			eof_q       <= last_col_s1 && last_row_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign end_of_line  = eol_q;
	assign end_of_frame = eof_q;

endmodule

// File: test/edh_checker.sv
`timescale 1ns / 100ps
// edh_checker: watches the register port and both pixel channels of the halftone block,
// keeps its own error diffusion state, predicts each output beat and compares it.
// depends on edh_pkg for the register indexes, pixel levels and error type
module edh_checker #(
	parameter int MAX_W = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_pixel,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_pixel,
	input  logic        end_of_line,
	input  logic        end_of_frame,
	output int          fail_count,
	output int          pending
);
	import edh_pkg::*;

	typedef struct packed {
		logic [PixW-1:0] tone;
		logic            eol;
		logic            eof;
	} tone_beat_t;

	tone_beat_t  expected_tones[$];
	tone_beat_t  oldest;
	logic [11:0] line_width;
	logic [15:0] line_count;
	logic [7:0]  threshold;
	err_t        below_errs[MAX_W];
	err_t        right_err;
	err_t        diag_err;
	int          col_pos;
	int          row_pos;

	function automatic int clamp_err(input int v);
		if (v > 1023) return 1023;
		if (v < -1024) return -1024;
		return v;
	endfunction

	function automatic tone_beat_t halftone_pixel(input logic [7:0] pix);
		int w;
		int h;
		int idx;
		int below;
		int corr;
		int delta;
		int part;
		logic last_col;
		logic last_row;
		tone_beat_t r;
		w = (line_width == 0) ? 1 : int'(line_width);
		if (w > MAX_W) w = MAX_W;
		h = (line_count == 0) ? 1 : int'(line_count);
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
		below = (row_pos > 0) ? int'(below_errs[idx]) : 0;
		corr = clamp_err(int'(pix) + int'(right_err) + below);
		r.tone = (corr > int'(threshold)) ? PixWhite : PixBlack;
		if (!last_row) begin
			if (!last_col) begin
				delta = corr - int'(r.tone);
				part = (3 * delta) / 8;
				below_errs[idx] = err_t'(clamp_err(part + int'(diag_err)));
				right_err = err_t'(part);
				diag_err = err_t'(delta / 4);
			end else begin
				below_errs[idx] = diag_err;
			end
		end
		r.eol = last_col;
		r.eof = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			right_err = '0;
			diag_err = '0;
			row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
		end else begin
			col_pos++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width = LineWidthRst;
			line_count = LineCountRst;
			threshold = ThresholdRst;
			right_err = '0;
			diag_err = '0;
			col_pos = 0;
			row_pos = 0;
			expected_tones.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
				REG_LINE_WIDTH: line_width = pwdata[11:0];
				REG_LINE_COUNT: line_count = pwdata[15:0];
				REG_THRESHOLD:  threshold = pwdata[7:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_tones.size() == 0) begin
					$error("out_pixel: expected nothing, got %0d", out_pixel);
					fail_count++;
				end else begin
					oldest = expected_tones.pop_front();
					if (out_pixel !== oldest.tone) begin
						$error("out_pixel: expected %0d, got %0d", oldest.tone, out_pixel);
						fail_count++;
					end
					if (end_of_line !== oldest.eol) begin
						$error("end_of_line: expected %0d, got %0d", oldest.eol, end_of_line);
						fail_count++;
					end
					if (end_of_frame !== oldest.eof) begin
						$error("end_of_frame: expected %0d, got %0d", oldest.eof, end_of_frame);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_tones.push_back(halftone_pixel(in_pixel));
			end
			pending = expected_tones.size();
		end
	end

endmodule

// File: test/tb_error_diffusion_halftone.sv
`timescale 1ns / 100ps
// tb_error_diffusion_halftone: drives frames of gray pixels and register settings
// into error_diffusion_halftone; edh_checker beside it predicts and compares the beats
module tb_error_diffusion_halftone;
	import edh_pkg::*;

	localparam int          TONE_TARGET   = 1430;
	localparam int          HOLD_CYCLES   = 120;
	localparam int          QUIET_LIMIT   = 3000;
	localparam int          MAX_W         = 2048;
	localparam logic [3:0]  UNMAPPED_ADDR = 4'hC;
	localparam logic [7:0]  OPENING[12]   = '{8'd0, 8'd255, 8'd128, 8'd127,
		8'd1, 8'd254, 8'd200, 8'd60, 8'd255, 8'd0, 8'd255, 8'd0};

	typedef enum {TONE_NOISE, TONE_EXTREME, TONE_FLAT, TONE_RAMP} tone_style_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_pixel;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_pixel;
	logic        end_of_line;
	logic        end_of_frame;
	int          fail_count;
	int          pending;

	int          sent;
	int          burst_left;
	bit          steady;
	bit          hold_req;
	int          col;
	int          row;
	int          pos_w;
	int          pos_h;
	tone_style_t style;
	logic [7:0]  flat_level;

	error_diffusion_halftone u_top (.*);

	edh_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] next_tone();
		case (style)
		TONE_NOISE:   return 8'($urandom);
		TONE_EXTREME: return ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 7) == 0);
		TONE_FLAT:    return flat_level;
		default:      return 8'(sent * 7);
		endcase
	endfunction

	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
		case (idx)
		REG_LINE_WIDTH: pos_w = (value[11:0] == 0) ? 1 : ((value[11:0] > MAX_W) ? MAX_W : value[11:0]);
		REG_LINE_COUNT: pos_h = (value[15:0] == 0) ? 1 : value[15:0];
		default: ;
		endcase
		apb_write({idx, 2'b00}, value);
	endtask

	task automatic feed(input logic [7:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				in_pixel <= 8'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_pixel <= pix;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
		if (col >= pos_w - 1) begin
			col = 0;
			row = (row >= pos_h - 1) ? 0 : row + 1;
		end else begin
			col++;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin : receiver
		stall_mode_t mode;
		int left;
		out_stall = 1'b0;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= ((left % 8) < 3);
			endcase
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
			else quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int pick;
		int w_val;
		int h_val;
		int frame;
		int n;
		bit pressure;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_pixel = '0;
		hold_req = 1'b0;
		steady = 1'b0;
		sent = 0;
		burst_left = 0;
		col = 0;
		row = 0;
		pos_w = LineWidthRst;
		pos_h = LineCountRst;
		style = TONE_NOISE;
		flat_level = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// small frame: first row, middle row, last row and last column
		set_reg(REG_LINE_WIDTH, 4);
		set_reg(REG_LINE_COUNT, 3);
		set_reg(REG_THRESHOLD, 127);
		foreach (OPENING[i]) feed(OPENING[i]);
		settle();
		// zero width and count act as one, so every beat ends a frame
		set_reg(REG_THRESHOLD, 0);
		set_reg(REG_LINE_WIDTH, 0);
		set_reg(REG_LINE_COUNT, 0);
		feed(8'd0);
		feed(8'd1);
		feed(8'd255);
		settle();
		set_reg(REG_THRESHOLD, 255);
		feed(8'd255);
		settle();
		apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
		set_reg(REG_LINE_WIDTH, 2);
		set_reg(REG_LINE_COUNT, 2);
		set_reg(REG_THRESHOLD, 128);
		repeat (4) feed(8'd255);
		settle();
		// shrink mid-frame so the next beat is forced to be the last
		set_reg(REG_LINE_WIDTH, 5);
		set_reg(REG_LINE_COUNT, 3);
		set_reg(REG_THRESHOLD, 100);
		repeat (7) feed(8'd180);
		settle();
		set_reg(REG_LINE_WIDTH, 2);
		set_reg(REG_LINE_COUNT, 2);
		feed(8'd90);
		settle();

		phase = 0;
		while (sent < TONE_TARGET) begin
			pressure = (phase % 7 == 1);
			if (phase == 2) begin
				w_val = 12'hFFF;
				h_val = 3;
			end else if (phase == 3) begin
				w_val = $urandom_range(1, 12);
				h_val = 16'hFFFF;
			end else if (pressure) begin
				w_val = $urandom_range(8, 20);
				h_val = $urandom_range(8, 12);
			end else begin
				pick = $urandom_range(0, 99);
				w_val = (pick < 70) ? $urandom_range(1, 12) : (pick < 88) ? $urandom_range(13, 80) :
					(pick < 94) ? 0 : $urandom_range(81, 400);
				pick = $urandom_range(0, 99);
				h_val = (pick < 60) ? $urandom_range(1, 5) : (pick < 82) ? $urandom_range(6, 12) :
					(pick < 92) ? 0 : (pick < 96) ? 16'hFFFF : $urandom_range(13, 40);
			end
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 7) == 0) apb_write(UNMAPPED_ADDR, $urandom);
			set_reg(REG_LINE_WIDTH, w_val);
			set_reg(REG_LINE_COUNT, h_val);
			set_reg(REG_THRESHOLD, (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
			style = tone_style_t'($urandom_range(0, 3));
			flat_level = 8'($urandom);
			frame = pos_w * pos_h;
			if (phase == 2) n = $urandom_range(40, 120);
			else if (pressure) n = frame * 2;
			else if (frame <= 240 && $urandom_range(0, 3) != 0) n = frame * $urandom_range(1, 3);
			else n = $urandom_range(1, (frame < 240) ? frame : 240);
			if (pressure) begin
				steady = 1'b1;
				hold_req = 1'b1;
			end
			repeat (n) feed(next_tone());
			steady = 1'b0;
			settle();
			if (col != 0 || row != 0) begin
				set_reg(REG_THRESHOLD, $urandom_range(0, 255));
				set_reg(REG_LINE_WIDTH, $urandom_range(0, (pos_w < 8) ? pos_w : 8));
				set_reg(REG_LINE_COUNT, $urandom_range(0, (pos_h < row + 3) ? pos_h : row + 3));
				while (col != 0 || row != 0) feed(next_tone());
				settle();
			end
			phase++;
		end

		settle();
		repeat (6) @(negedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/edh_pkg.sv
hdl/edh_ram.sv
hdl/error_diffusion_halftone.sv
test/edh_checker.sv
test/tb_error_diffusion_halftone.sv
